/* src/urs_pkg.sv */
package urs_pkg;

    // Echo width counter size
    localparam int ECHO_COUNT_BITS = 16;

    // Register and field widths
    localparam int TRIG_W     = 10;
    localparam int SETTLE_W   = 16;
    localparam int INTERVAL_W = 22;
    localparam int SPEED_W    = 9;
    localparam int TIMER_W    = 22;
    localparam int DIST_W     = 11;
    localparam int CFG_DATA_W = 22;
    localparam int CFG_INDEX_W = 2;

    // Register reset values
    localparam logic [TRIG_W-1:0]     TRIG_RESET     = TRIG_W'(10);
    localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = SETTLE_W'(100);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000000);
    localparam logic [SPEED_W-1:0]    SPEED_RESET    = SPEED_W'(330);

    // Distance conversion: cm = speed * ticks / 20000, saturated
    localparam int PROD_W       = SPEED_W + ECHO_COUNT_BITS;
    localparam int DIST_DIVISOR = 20000;
    localparam int DIST_MAX_INT = 2047;
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(DIST_MAX_INT);
    localparam int DIST_LIMIT   = (DIST_MAX_INT + 1) * DIST_DIVISOR;
    localparam int CMP_W        = 34;
    // 20000 = 32 * 625: shift by 5, then multiply by a reciprocal of 625
    localparam int DIV_SHIFT    = 5;
    localparam int RECIP_X_W    = 21;
    localparam int RECIP_K      = 31;
    localparam int RECIP_M_W    = 22;
    localparam logic [RECIP_M_W-1:0] RECIP_M = RECIP_M_W'(3435974);
    localparam int RECIP_P_W    = RECIP_X_W + RECIP_M_W;

    localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;

    typedef enum logic [4:0] {
        PH_INTERVAL  = 5'b00001,
        PH_TRIGGER   = 5'b00010,
        PH_SETTLE    = 5'b00100,
        PH_WAIT_ECHO = 5'b01000,
        PH_COUNT     = 5'b10000
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRIGGER  = 2'd0,
        CFG_SETTLE   = 2'd1,
        CFG_INTERVAL = 2'd2,
        CFG_SPEED    = 2'd3
    } cfg_index_t;

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic trig;
        logic fire;
        logic ovf;
    } item_ctl_t;

endpackage

/* src/urs_in_if.sv */
interface urs_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

/* src/urs_out_if.sv */
interface urs_out_if;
    logic                     valid;
    logic                     ready;
    logic                     trigger_level;
    logic                     distance_valid;
    logic [urs_pkg::DIST_W-1:0] distance_cm;
    logic                     echo_overflow;

    modport source (output valid, output trigger_level, output distance_valid,
                    output distance_cm, output echo_overflow, input ready);
    modport sink   (input valid, input trigger_level, input distance_valid,
                    input distance_cm, input echo_overflow, output ready);
endinterface

/* src/urs_dist_conv.sv */
module urs_dist_conv (
    input  logic [urs_pkg::PROD_W-1:0] product,
    output logic [urs_pkg::DIST_W-1:0] distance
);

    logic [urs_pkg::CMP_W-1:0]     prod_ext;
    logic                          sat;
    logic [urs_pkg::RECIP_X_W-1:0] scaled;
    logic [urs_pkg::RECIP_P_W-1:0] recip_prod;

    // Saturate above the largest reportable distance
    assign prod_ext = urs_pkg::CMP_W'(product);
    assign sat      = prod_ext >= urs_pkg::CMP_W'(urs_pkg::DIST_LIMIT);

    // Divide by 32 with a shift, then by 625 with a reciprocal multiply
    assign scaled     = prod_ext[urs_pkg::DIV_SHIFT +: urs_pkg::RECIP_X_W];
    assign recip_prod = urs_pkg::RECIP_P_W'(scaled)
                      * urs_pkg::RECIP_P_W'(urs_pkg::RECIP_M);

    assign distance = sat ? urs_pkg::DIST_MAX
                          : recip_prod[urs_pkg::RECIP_K +: urs_pkg::DIST_W];

endmodule

/* src/ultrasonic_range_sequencer_unit.sv */
// Path: the input register, the phase and product stage and the distance
//   output register, which advance together and hold while range_out stalls.
// Throughput: one tick word per cycle while the output register is free or taken.
// Reset (rst_n low, asynchronous): all registers but s2_prod_reg take
//   their default values, the sequencer starts in the interval wait with a zero
//   timer, and the reported distance and overflow flag read zero. No clearing pass.
module ultrasonic_range_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [urs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [urs_pkg::CFG_DATA_W-1:0]    cfg_data,
    urs_in_if.sink                            echo_in,
    urs_out_if.source                         range_out
);

    // Configuration registers
    logic [urs_pkg::TRIG_W-1:0]     trigger_ticks_reg;
    logic [urs_pkg::SETTLE_W-1:0]   settle_ticks_reg;
    logic [urs_pkg::INTERVAL_W-1:0] interval_ticks_reg;
    logic [urs_pkg::SPEED_W-1:0]    sound_speed_reg;

    // Sequencer state
    urs_pkg::phase_t                    phase_reg, phase_next;
    logic [urs_pkg::TIMER_W-1:0]        phase_timer_reg, phase_timer_next;
    logic [urs_pkg::TIMER_W-1:0]        timer_inc;
    logic [urs_pkg::ECHO_COUNT_BITS-1:0] echo_width_reg, echo_width_next;
    logic                               overflow_reg, overflow_next;

    // Pipeline
    logic                        adv;
    logic                        step;
    logic                        s1_valid_reg;
    logic                        s1_echo_reg;
    logic                        s2_valid_reg;
    urs_pkg::item_ctl_t          s1_ctl;
    urs_pkg::item_ctl_t          s2_ctl_reg;
    logic [urs_pkg::PROD_W-1:0]  s2_prod_reg;
    logic [urs_pkg::DIST_W-1:0]  dist_conv;
    logic                        out_valid_reg;
    logic                        out_trig_reg;
    logic                        out_dval_reg;
    logic                        out_ovf_reg;
    logic [urs_pkg::DIST_W-1:0]  last_distance_reg;

    // All stages move when the output register is free or being taken
    assign adv           = !out_valid_reg || range_out.ready;
    assign echo_in.ready = adv;
    assign step          = s1_valid_reg && adv;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg  <= urs_pkg::TRIG_RESET;
            settle_ticks_reg   <= urs_pkg::SETTLE_RESET;
            interval_ticks_reg <= urs_pkg::INTERVAL_RESET;
            sound_speed_reg    <= urs_pkg::SPEED_RESET;
        end
        else if (cfg_we)
        begin
            case (urs_pkg::cfg_index_t'(cfg_index))
                urs_pkg::CFG_TRIGGER:
                    trigger_ticks_reg  <= cfg_data[urs_pkg::TRIG_W-1:0];
                urs_pkg::CFG_SETTLE:
                    settle_ticks_reg   <= cfg_data[urs_pkg::SETTLE_W-1:0];
                urs_pkg::CFG_INTERVAL:
                    interval_ticks_reg <= cfg_data[urs_pkg::INTERVAL_W-1:0];
                urs_pkg::CFG_SPEED:
                    sound_speed_reg    <= cfg_data[urs_pkg::SPEED_W-1:0];
                default:
                    trigger_ticks_reg  <= trigger_ticks_reg;
            endcase
        end
    end

    // Capture the incoming tick word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_echo_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= echo_in.valid;
            s1_echo_reg  <= echo_in.echo_level;
        end
    end

    // Advance the ranging sequence by one tick
    assign timer_inc = phase_timer_reg + urs_pkg::TIMER_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        phase_timer_next = phase_timer_reg;
        echo_width_next  = echo_width_reg;
        overflow_next    = overflow_reg;
        s1_ctl           = '0;
        case (phase_reg)
            urs_pkg::PH_INTERVAL:
            begin
                phase_timer_next = timer_inc;
                if (timer_inc >= urs_pkg::TIMER_W'(interval_ticks_reg)
                    || timer_inc == '0)
                begin
                    phase_next       = urs_pkg::PH_TRIGGER;
                    phase_timer_next = '0;
                end
            end
            urs_pkg::PH_TRIGGER:
            begin
                s1_ctl.trig      = 1'b1;
                phase_timer_next = timer_inc;
                if (timer_inc >= urs_pkg::TIMER_W'(trigger_ticks_reg))
                begin
                    phase_next       = (settle_ticks_reg == '0) ? urs_pkg::PH_WAIT_ECHO
                                                                 : urs_pkg::PH_SETTLE;
                    phase_timer_next = '0;
                end
            end
            urs_pkg::PH_SETTLE:
            begin
                phase_timer_next = timer_inc;
                if (timer_inc >= urs_pkg::TIMER_W'(settle_ticks_reg))
                begin
                    phase_next       = urs_pkg::PH_WAIT_ECHO;
                    phase_timer_next = '0;
                end
            end
            urs_pkg::PH_WAIT_ECHO:
            begin
                if (s1_echo_reg)
                begin
                    phase_next      = urs_pkg::PH_COUNT;
                    echo_width_next = urs_pkg::ECHO_COUNT_BITS'(1);
                    overflow_next   = 1'b0;
                end
            end
            urs_pkg::PH_COUNT:
            begin
                if (s1_echo_reg)
                begin
                    // Hold at full scale and flag it
                    if (echo_width_reg == urs_pkg::ECHO_MAX)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        echo_width_next = echo_width_reg
                                        + urs_pkg::ECHO_COUNT_BITS'(1);
                    end
                end
                else
                begin
                    s1_ctl.fire      = 1'b1;
                    phase_next       = urs_pkg::PH_INTERVAL;
                    phase_timer_next = '0;
                end
            end
            default:
            begin
                phase_next       = urs_pkg::PH_INTERVAL;
                phase_timer_next = '0;
            end
        endcase
        s1_ctl.ovf = overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= urs_pkg::PH_INTERVAL;
            phase_timer_reg <= '0;
            echo_width_reg  <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            phase_timer_reg <= phase_timer_next;
            echo_width_reg  <= echo_width_next;
            overflow_reg    <= overflow_next;
        end
    end

    // Register the word's control and the speed-width product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ctl_reg   <= '0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_ctl_reg   <= s1_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_prod_reg <= urs_pkg::PROD_W'(sound_speed_reg) * urs_pkg::PROD_W'(echo_width_reg);
        end
    end

    // Convert the product to centimetres
    urs_dist_conv u_dist_conv (
        .product  (s2_prod_reg),
        .distance (dist_conv)
    );

    // Load the result word and keep the last distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            out_trig_reg      <= 1'b0;
            out_dval_reg      <= 1'b0;
            out_ovf_reg       <= 1'b0;
            last_distance_reg <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                out_trig_reg <= s2_ctl_reg.trig;
                out_dval_reg <= s2_ctl_reg.fire;
                out_ovf_reg  <= s2_ctl_reg.ovf;
                if (s2_ctl_reg.fire)
                begin
                    last_distance_reg <= dist_conv;
                end
            end
        end
    end

    assign range_out.valid          = out_valid_reg;
    assign range_out.trigger_level  = out_trig_reg;
    assign range_out.distance_valid = out_dval_reg;
    assign range_out.distance_cm    = last_distance_reg;
    assign range_out.echo_overflow  = out_ovf_reg;

    // A finished measurement never coincides with the trigger pulse
    a_valid_no_trig: assert property (@(posedge clk) disable iff (!rst_n)
        range_out.valid && range_out.distance_valid |-> !range_out.trigger_level)
        else $error("distance strobe together with trigger");

    // A falling echo returns the sequencer to the interval wait
    a_fire_to_interval: assert property (@(posedge clk) disable iff (!rst_n)
        step && s1_ctl.fire |=> phase_reg == urs_pkg::PH_INTERVAL
                                && phase_timer_reg == '0)
        else $error("sequencer did not restart the interval");

    // The overflow flag is only set with the counter at full scale
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> echo_width_reg == urs_pkg::ECHO_MAX)
        else $error("overflow flag without saturated counter");

endmodule
